// ----- hdl/gdr_pkg.sv -----
// Package: shared widths, register indexes and constants of the 5x5 reduce block.
`timescale 1ns / 1ps
package gdr_pkg;

    localparam int PIX_W          = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int OUT_WIDTH_W    = 9;
    localparam int OUT_HEIGHT_W   = 12;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 12;
    localparam int ROW_W          = 14;
    localparam int HSUM_W         = 12;
    localparam int VSUM_W         = 16;
    localparam int NUM_LINES      = 4;

    localparam logic [ROW_W-1:0] ROW_LIMIT = 14'd16383;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_WIDTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_HEIGHT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_PHASE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COL_PHASE   = 3'd4;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [HSUM_W-1:0] hsum_t;

endpackage

// ----- hdl/gdr_if.sv -----
// Interfaces: source pixel channel, result channel and configuration write channel.
`timescale 1ns / 1ps
interface gdr_in_if import gdr_pkg::*;;
    logic valid;
    logic ready;
    pix_t pixel;
    logic frame_start;
    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface gdr_out_if import gdr_pkg::*;;
    logic valid;
    logic ready;
    pix_t out_pixel;
    logic row_end;
    logic frame_end;
    modport source (output valid, output out_pixel, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input out_pixel, input row_end, input frame_end,
                    output ready);
endinterface

interface gdr_cfg_if import gdr_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/gdr_ram.sv -----
// Generic single-write, single-read RAM with registered, read-first output.
`timescale 1ns / 1ps
module gdr_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/gaussian_5x5_half_downscale_core.sv -----
// Top level: streaming 5x5 binomial blur with 2:1 decimation (pyramid reduce).
`timescale 1ns / 1ps
//
// Usage
//   pix_in  : source pixels in raster order, margins included, frame_width per row.
//             frame_start on a beat restarts the row and column counters.
//   pix_out : one beat per destination pixel; row_end marks the last pixel of a
//             destination row, frame_end the last pixel of the frame.
//   cfg     : register writes (index, data), always ready; write only while idle.
// Timing
//   One source beat per clock unless pix_out stalls. The beat closing a 5x5
//   window passes the line-store read stage, then the output register. The limit
//   is the line store: four RAM banks, each read once and one written per beat.
// Stall
//   A stalled pix_out holds the output register; one more beat waits in the
//   line-store read stage, after which pix_in.ready drops until the sink takes
//   the result.
// Reset
//   Registers return to their defaults, counters and the pixel window clear.
//   Line-store contents are left as they are; no clearing pass is needed.
//
module gaussian_5x5_half_downscale_core import gdr_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    gdr_in_if.sink    pix_in,
    gdr_out_if.source pix_out,
    gdr_cfg_if.sink   cfg
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (WW > FRAME_WIDTH_W) ? WW : FRAME_WIDTH_W;
    localparam int OXW = ((CW > OUT_WIDTH_W) ? CW : OUT_WIDTH_W) + 1;
    localparam int OYW = ROW_W + 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [FRAME_WIDTH_W-1:0] frame_width_reg;
    logic [OUT_WIDTH_W-1:0]   out_width_reg;
    logic [OUT_HEIGHT_W-1:0]  out_height_reg;
    logic                     row_phase_reg;
    logic                     col_phase_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= 11'd1024;
            out_width_reg   <= 9'd510;
            out_height_reg  <= 12'd1;
            row_phase_reg   <= 1'b0;
            col_phase_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH: frame_width_reg <= cfg.data[FRAME_WIDTH_W-1:0];
                REG_OUT_WIDTH:   out_width_reg   <= cfg.data[OUT_WIDTH_W-1:0];
                REG_OUT_HEIGHT:  out_height_reg  <= cfg.data[OUT_HEIGHT_W-1:0];
                REG_ROW_PHASE:   row_phase_reg   <= cfg.data[0];
                REG_COL_PHASE:   col_phase_reg   <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline handshake
    // ---------------------------------------------------------------
    logic rd_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic in_accept;

    assign out_free     = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = !rd_valid_reg || out_free;
    assign in_accept    = pix_in.valid && pix_in.ready;

    // ---------------------------------------------------------------
    // Position of the incoming beat
    // ---------------------------------------------------------------
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [EW-1:0]    fw_ext;
    logic [EW-1:0]    width_eff;
    logic [CW-1:0]    col_base;
    logic [CW-1:0]    col_cur;
    logic [ROW_W-1:0] row_cur;

    always_comb
    begin
        fw_ext = EW'(frame_width_reg);
        if (fw_ext == '0)
        begin
            width_eff = EW'(1);
        end
        else if (fw_ext > EW'(MAX_WIDTH))
        begin
            width_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = fw_ext;
        end

        // Frame start restarts both counters before the pixel is placed
        col_base = pix_in.frame_start ? '0 : col_reg;
        row_cur  = pix_in.frame_start ? '0 : row_reg;
        col_cur  = (EW'(col_base) >= width_eff) ? '0 : col_base;

        if (EW'(col_cur) + EW'(1) >= width_eff)
        begin
            col_next = '0;
            row_next = (row_cur < ROW_LIMIT) ? row_cur + ROW_W'(1) : row_cur;
        end
        else
        begin
            col_next = col_cur + CW'(1);
            row_next = row_cur;
        end
    end

    // ---------------------------------------------------------------
    // Horizontal 1-4-6-4-1 sum over the pixel window and the new pixel
    // ---------------------------------------------------------------
    pix_t [3:0] win_reg;
    hsum_t      hsum;

    assign hsum = hsum_t'(win_reg[0]) + (hsum_t'(win_reg[1]) << 2)
                + (hsum_t'(win_reg[2]) << 2) + (hsum_t'(win_reg[2]) << 1)
                + (hsum_t'(win_reg[3]) << 2) + hsum_t'(pix_in.pixel);

    // ---------------------------------------------------------------
    // Output decision, taken with the beat
    // ---------------------------------------------------------------
    logic [OXW-1:0] c_x, c_min, ox;
    logic [OYW-1:0] r_x, r_min, oy;
    logic           emit, re_flag, fe_flag;

    always_comb
    begin
        c_x     = OXW'(col_cur);
        c_min   = OXW'(4) + OXW'(col_phase_reg);
        ox      = (c_x - c_min) >> 1;
        r_x     = OYW'(row_cur);
        r_min   = OYW'(4) + OYW'(row_phase_reg);
        oy      = (r_x - r_min) >> 1;
        emit    = (c_x >= c_min) && (r_x >= r_min)
               && ((col_cur[0] ^ col_phase_reg) == 1'b0)
               && ((row_cur[0] ^ row_phase_reg) == 1'b0)
               && (ox < OXW'(out_width_reg)) && (oy < OYW'(out_height_reg));
        re_flag = (ox + OXW'(1) == OXW'(out_width_reg));
        fe_flag = re_flag && (oy + OYW'(1) == OYW'(out_height_reg));
    end

    // ---------------------------------------------------------------
    // Line store: bank k holds the sums of rows with row index mod 4 == k.
    // Read all banks at the column, write the current row's bank in place.
    // ---------------------------------------------------------------
    hsum_t rd_data [NUM_LINES];

    for (genvar k = 0; k < NUM_LINES; k++)
    begin : g_line
        gdr_ram #(
            .WIDTH (HSUM_W),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .clk   (clk),
            .we    (in_accept && (row_cur[1:0] == 2'(k))),
            .waddr (col_cur),
            .wdata (hsum),
            .re    (in_accept),
            .raddr (col_cur),
            .rdata (rd_data[k])
        );
    end

    // ---------------------------------------------------------------
    // Counters and pixel window
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            win_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                win_reg      <= {pix_in.pixel, win_reg[3:1]};
                rd_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                rd_valid_reg <= 1'b0;
            end
        end
    end

    // Read-stage payload: advances only with a beat, as the RAM outputs do
    hsum_t      hsum_reg;
    logic [1:0] bank_reg;
    logic       emit_reg, re_reg, fe_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hsum_reg <= hsum;
            bank_reg <= row_cur[1:0];
            emit_reg <= emit;
            re_reg   <= re_flag;
            fe_reg   <= fe_flag;
        end
    end

    // ---------------------------------------------------------------
    // Vertical 1-4-6-4-1 combine: oldest row, three rows, two rows, one row back
    // ---------------------------------------------------------------
    logic [VSUM_W-1:0] l4, l3, l2, l1, vsum;

    always_comb
    begin
        l4   = VSUM_W'(rd_data[bank_reg]);
        l3   = VSUM_W'(rd_data[bank_reg + 2'd1]);
        l2   = VSUM_W'(rd_data[bank_reg + 2'd2]);
        l1   = VSUM_W'(rd_data[bank_reg + 2'd3]);
        vsum = l4 + (l3 << 2) + (l2 << 2) + (l2 << 1) + (l1 << 2) + VSUM_W'(hsum_reg);
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    pix_t out_pixel_reg;
    logic out_row_end_reg, out_frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= rd_valid_reg && emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && rd_valid_reg && emit_reg)
        begin
            out_pixel_reg     <= vsum[15:8];
            out_row_end_reg   <= re_reg;
            out_frame_end_reg <= fe_reg;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_pixel = out_pixel_reg;
    assign pix_out.row_end   = out_row_end_reg;
    assign pix_out.frame_end = out_frame_end_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
`ifndef SYNTHESIS
    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_frame_end_reg |-> out_row_end_reg)
        else $error("frame_end without row_end");

    a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_in.ready |-> rd_valid_reg && out_valid_reg)
        else $error("input stalled with a free pipeline");

    a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg && !out_free |=> rd_valid_reg && $stable(hsum_reg)
            && $stable(bank_reg))
        else $error("read stage lost its beat under stall");
`endif

endmodule

// ----- dv/tb_gaussian_5x5_half_downscale_core.sv -----
// Self-checking testbench of the 5x5 binomial blur with 2:1 decimation.
`timescale 1ns / 1ps
//
// Source pixels are streamed in raster order through the pix_in channel. Every
// accepted beat also goes through a predictor that keeps its own line store,
// pixel window, row and column counters and register copies. Expected
// destination pixels wait in a queue. Each accepted pix_out beat is compared
// with the oldest of them.
//
// Registers are reprogrammed only when the block is idle: the source queue is
// empty, every expected pixel has arrived, and a short drain has passed. After
// each reprogramming the next frame begins with frame_start, so the line store
// is never read at a column that no beat has written.
//
module tb_gaussian_5x5_half_downscale_core;
    import gdr_pkg::*;

    localparam int LINE_LEN     = 1024;   // MAX_WIDTH of the instance
    localparam int DRAIN_CYCLES = 8;      // lets beats without a result leave the read and output stages
    localparam int QUIET_LIMIT  = 2000;   // cycles with no beat on any channel
    localparam int RANDOM_BEATS = 300;
    localparam int CALM_BEATS   = 200;    // no idling after this many random beats

    typedef struct packed {
        pix_t pixel;
        logic frame_start;
    } src_beat_t;

    typedef struct packed {
        pix_t out_pixel;
        logic row_end;
        logic frame_end;
    } dst_pix_t;

    typedef enum int {PAT_RANDOM, PAT_WHITE, PAT_BLACK, PAT_CHECKER} pix_pattern_t;

    logic clk;
    logic rst_n;

    gdr_in_if  src_bus ();
    gdr_out_if dst_bus ();
    gdr_cfg_if reg_bus ();

    gaussian_5x5_half_downscale_core #(
        .MAX_WIDTH (LINE_LEN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (src_bus),
        .pix_out (dst_bus),
        .cfg     (reg_bus)
    );

    // ------------------------------------------------------------------
    // Predictor state: register copies at their reset values, line store
    // of horizontal 5-tap sums, the last four source pixels, position.
    // ------------------------------------------------------------------
    logic [FRAME_WIDTH_W-1:0] fw_r = 11'd1024;
    logic [OUT_WIDTH_W-1:0]   ow_r = 9'd510;
    logic [OUT_HEIGHT_W-1:0]  oh_r = 12'd1;
    logic                     rp_r = 1'b0;
    logic                     cp_r = 1'b0;

    bit [HSUM_W-1:0]  line_sums [NUM_LINES*LINE_LEN];
    pix_t             pix_hist [4] = '{default: '0};
    logic [9:0]       col_pos = '0;
    logic [ROW_W-1:0] row_pos = '0;

    src_beat_t src_pending [$];   // source beats not yet driven
    dst_pix_t  dst_expect [$];    // destination pixels still to arrive

    int unsigned src_gap;
    int unsigned dst_stall;
    bit          calm;
    int unsigned src_beats;
    int unsigned dst_beats;
    int unsigned reg_writes;
    int unsigned errors;
    int unsigned quiet_cycles;

    // Advance the predictor by one accepted source beat and queue the
    // destination pixel it completes, if any.
    task automatic blur_decimate_step(input pix_t p, input logic fs);
        int unsigned w;
        int unsigned c;
        int unsigned r;
        int unsigned h;
        int unsigned v;
        int unsigned ox;
        int unsigned oy;
        dst_pix_t    res;
        // A width of zero behaves as one; anything above the store as the store.
        w = (fw_r == 0) ? 1 : ((fw_r > LINE_LEN) ? LINE_LEN : fw_r);
        if (fs)
        begin
            col_pos = '0;
            row_pos = '0;
        end
        if (col_pos >= w)
            col_pos = '0;
        c = 32'(col_pos);
        r = 32'(row_pos);

        h = pix_hist[0] + 4 * pix_hist[1] + 6 * pix_hist[2] + 4 * pix_hist[3] + p;
        // Line (r & 3) holds row r-4, (r+1) & 3 row r-3, and so on.
        v = line_sums[(r & 3) * LINE_LEN + c]
            + 4 * line_sums[((r + 1) & 3) * LINE_LEN + c]
            + 6 * line_sums[((r + 2) & 3) * LINE_LEN + c]
            + 4 * line_sums[((r + 3) & 3) * LINE_LEN + c]
            + h;

        if (c >= 4 + cp_r && r >= 4 + rp_r
            && ((c - 4 - cp_r) % 2) == 0 && ((r - 4 - rp_r) % 2) == 0)
        begin
            ox = (c - 4 - cp_r) / 2;
            oy = (r - 4 - rp_r) / 2;
            if (ox < ow_r && oy < oh_r)
            begin
                res.out_pixel = pix_t'(v >> 8);
                res.row_end   = (ox + 1 == ow_r);
                res.frame_end = res.row_end && (oy + 1 == oh_r);
                dst_expect.push_back(res);
            end
        end

        line_sums[(r & 3) * LINE_LEN + c] = h[HSUM_W-1:0];
        pix_hist[0] = pix_hist[1];
        pix_hist[1] = pix_hist[2];
        pix_hist[2] = pix_hist[3];
        pix_hist[3] = p;

        // Row counter saturates at its limit instead of wrapping.
        if (c + 1 >= w)
        begin
            col_pos = '0;
            if (row_pos < ROW_LIMIT)
                row_pos = row_pos + 1'b1;
        end
        else
            col_pos = 10'(c + 1);
    endtask

    // ------------------------------------------------------------------
    // Clock and the single reset at the start of the run.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        // Known values on every input from time zero.
        rst_n               = 1'b0;
        src_bus.valid       = 1'b0;
        src_bus.pixel       = '0;
        src_bus.frame_start = 1'b0;
        dst_bus.ready       = 1'b0;
        reg_bus.valid       = 1'b0;
        reg_bus.index       = REG_FRAME_WIDTH;
        reg_bus.data        = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Source driver: feed beats from the pending queue, hold a beat until
    // it is taken, and insert short idle bursts unless the run is calm.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : src_driver
        src_beat_t nxt;
        if (!rst_n)
        begin
            src_bus.valid       <= 1'b0;
            src_bus.pixel       <= '0;
            src_bus.frame_start <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (src_bus.valid && src_bus.ready)
            begin
                blur_decimate_step(src_bus.pixel, src_bus.frame_start);
                src_beats++;
            end
            // Only move on once the current beat is gone; one assignment per step.
            if (!src_bus.valid || src_bus.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    src_bus.valid <= 1'b0;
                end
                else if (src_pending.size() != 0)
                begin
                    nxt = src_pending.pop_front();
                    src_bus.valid       <= 1'b1;
                    src_bus.pixel       <= nxt.pixel;
                    src_bus.frame_start <= nxt.frame_start;
                    if (!calm && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 3);
                end
                else
                    src_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: stall ready in bursts, check each taken beat against
    // the oldest expected pixel.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : dst_monitor
        dst_pix_t got;
        dst_pix_t want;
        if (!rst_n)
        begin
            dst_bus.ready <= 1'b0;
            dst_stall = 0;
        end
        else
        begin
            if (dst_bus.valid && dst_bus.ready)
            begin
                got = {dst_bus.out_pixel, dst_bus.row_end, dst_bus.frame_end};
                dst_beats++;
                if (dst_expect.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected pixel: expected none, got px=%0d re=%0b fe=%0b",
                             $time, got.out_pixel, got.row_end, got.frame_end);
                end
                else
                begin
                    want = dst_expect.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                 $time, want.out_pixel, want.row_end, want.frame_end,
                                 got.out_pixel, got.row_end, got.frame_end);
                    end
                end
            end
            if (dst_stall > 0)
            begin
                dst_stall--;
                dst_bus.ready <= 1'b0;
            end
            else
            begin
                dst_bus.ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    dst_stall = $urandom_range(1, 3);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no channel moves a beat for too long.
    // Stall bursts and the drain pause are far shorter than the limit.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_bus.valid && src_bus.ready) || (dst_bus.valid && dst_bus.ready)
                || (reg_bus.valid && reg_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d pixels still expected",
                         $time, quiet_cycles, dst_expect.size());
                $display("tb_gaussian_5x5_half_downscale_core: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Write one register and mirror it into the predictor once the beat is taken.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.data  <= val;
        do
            @(posedge clk);
        while (!reg_bus.ready);
        reg_bus.valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH: fw_r = val[FRAME_WIDTH_W-1:0];
            REG_OUT_WIDTH:   ow_r = val[OUT_WIDTH_W-1:0];
            REG_OUT_HEIGHT:  oh_r = val[OUT_HEIGHT_W-1:0];
            REG_ROW_PHASE:   rp_r = val[0];
            REG_COL_PHASE:   cp_r = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Fill the unused upper data bits with noise; the block must drop them.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input int unsigned v, input int w);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom);
        for (int k = 0; k < w; k++)
            d[k] = v[k];
        return d;
    endfunction

    task automatic program_regs(input int unsigned fw, input int unsigned ow,
                                input int unsigned oh, input int unsigned rp,
                                input int unsigned cp);
        write_reg(REG_FRAME_WIDTH, with_junk(fw, FRAME_WIDTH_W));
        write_reg(REG_OUT_WIDTH,   with_junk(ow, OUT_WIDTH_W));
        write_reg(REG_OUT_HEIGHT,  with_junk(oh, OUT_HEIGHT_W));
        write_reg(REG_ROW_PHASE,   with_junk(rp, 1));
        write_reg(REG_COL_PHASE,   with_junk(cp, 1));
    endtask

    task automatic queue_frame(input int unsigned n, input bit with_start,
                               input pix_pattern_t pat);
        src_beat_t b;
        for (int unsigned i = 0; i < n; i++)
        begin
            case (pat)
                PAT_WHITE:   b.pixel = 8'hFF;
                PAT_BLACK:   b.pixel = 8'h00;
                PAT_CHECKER: b.pixel = i[0] ? 8'hFF : 8'h00;
                default:     b.pixel = pix_t'($urandom);
            endcase
            b.frame_start = with_start && (i == 0);
            src_pending.push_back(b);
        end
    endtask

    // Wait until every queued beat is taken and every expected pixel has
    // arrived, then let the pipeline drain beats that make no result.
    task automatic settle();
        while (src_pending.size() != 0 || src_bus.valid)
            @(posedge clk);
        while (dst_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        int unsigned rnd_beats;
        int unsigned fw;
        int unsigned ow;
        int unsigned oh;
        int unsigned rp;
        int unsigned cp;
        int unsigned rows;
        int unsigned n;
        int unsigned frames;

        calm = 1'b0;
        rnd_beats = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Smallest frame with an output: full white, full black, checkerboard.
        program_regs(5, 1, 1, 0, 0);
        queue_frame(25, 1'b1, PAT_WHITE);
        queue_frame(25, 1'b1, PAT_BLACK);
        queue_frame(25, 1'b1, PAT_CHECKER);
        settle();

        // Odd row and column phase on a 6x6 frame.
        program_regs(6, 1, 1, 1, 1);
        queue_frame(36, 1'b1, PAT_RANDOM);
        settle();

        // Zero width acts as one, and a 4-pixel row never yields a pixel.
        program_regs(0, 1, 1, 0, 0);
        queue_frame(12, 1'b1, PAT_RANDOM);
        settle();
        program_regs(4, 1, 1, 0, 0);
        queue_frame(40, 1'b1, PAT_RANDOM);
        settle();

        // Zero destination width, then zero destination height.
        program_regs(9, 0, 3, 0, 0);
        queue_frame(9 * 12, 1'b1, PAT_RANDOM);
        settle();
        program_regs(9, 3, 0, 0, 0);
        queue_frame(9 * 12, 1'b1, PAT_RANDOM);
        settle();

        // Destination row wider than the source allows: row_end never shows.
        program_regs(12, 510, 2, 1, 0);
        queue_frame(12 * 10, 1'b1, PAT_RANDOM);
        settle();

        // Rows past the frame without a frame start, then a restart mid-frame.
        program_regs(7, 2, 2, 0, 1);
        queue_frame(7 * 14, 1'b1, PAT_RANDOM);
        queue_frame(7 * 10, 1'b0, PAT_RANDOM);
        queue_frame(7 * 6, 1'b1, PAT_RANDOM);
        queue_frame(7 * 9, 1'b1, PAT_RANDOM);
        settle();

        // Random configurations, mostly small, each with a few frames.
        while (rnd_beats < RANDOM_BEATS)
        begin
            fw = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 32)
                                              : $urandom_range(5, 16);
            case ($urandom_range(0, 9))
                0:       ow = 0;
                1:       ow = 510;
                default: ow = $urandom_range(1, 8);
            endcase
            oh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            rp = $urandom_range(0, 1);
            cp = $urandom_range(0, 1);
            program_regs(fw, ow, oh, rp, cp);
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++)
            begin
                rows = 4 + rp + 2 * oh + $urandom_range(0, 2);
                n = fw * rows;
                // Noise: cut a frame short, or drop the frame start.
                if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(1, n);
                queue_frame(n, (f == 0) || ($urandom_range(0, 9) != 0), PAT_RANDOM);
                rnd_beats += n;
            end
            if (rnd_beats >= CALM_BEATS)
                calm = 1'b1;
            settle();
        end

        if (dst_expect.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected pixels never arrived", $time, dst_expect.size());
        end
        $display("covered %0d source beats, %0d destination pixels, %0d register writes",
                 src_beats, dst_beats, reg_writes);
        $display("frame widths from 0 to 32, both phases, empty and clipped outputs, lost starts");
        if (errors == 0)
            $display("tb_gaussian_5x5_half_downscale_core: clean");
        else
            $display("tb_gaussian_5x5_half_downscale_core: errors");
        $finish;
    end

endmodule
